### rtl/core/rsqt_pkg.sv
// ----------------------------------------------------------------------------
// Read sample, clip and quality trim: shared definitions
// Sizes, register indexes, reset values and the read summary record that
// the window tracker hands to the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rsqt_pkg;

    // Read and window limits
    localparam int MAX_READ_LEN = 2048;
    localparam int MAX_WINDOW   = 32;

    localparam int POS_W     = 12;                       // base position, holds MAX_READ_LEN
    localparam int QUAL_W    = 7;                        // quality character / Phred value
    localparam int WIN_W     = 6;                        // window size register
    localparam int WIN_IDX_W = $clog2(MAX_WINDOW);       // delay line slot index
    localparam int SUM_W     = $clog2(MAX_READ_LEN * 95); // window sum, never wraps in a read
    localparam int DRAW_W    = 14;
    localparam int THR_W     = 13;                       // quality threshold times window size

    localparam logic [QUAL_W-1:0] PHRED_OFFSET = QUAL_W'(33);

    // Counter widths
    localparam int READS_W = 32;
    localparam int BASES_W = 40;
    localparam logic [BASES_W-1:0] BASES_MAX = {BASES_W{1'b1}};

    // Stream payload widths (padded to whole bytes)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 136;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_THRESHOLD  = 3'd0,
        REG_LEFT_CLIP         = 3'd1,
        REG_RIGHT_CLIP        = 3'd2,
        REG_MIN_LENGTH        = 3'd3,
        REG_MAX_LENGTH        = 3'd4,
        REG_QUALITY_THRESHOLD = 3'd5,
        REG_WINDOW_SIZE       = 3'd6
    } cfg_reg_t;

    // Register reset values
    localparam logic [DRAW_W-1:0] RST_SAMPLE_THRESHOLD  = DRAW_W'(5000);
    localparam logic [POS_W-1:0]  RST_LEFT_CLIP         = POS_W'(17);
    localparam logic [POS_W-1:0]  RST_RIGHT_CLIP        = POS_W'(0);
    localparam logic [POS_W-1:0]  RST_MIN_LENGTH        = POS_W'(50);
    localparam logic [POS_W-1:0]  RST_MAX_LENGTH        = POS_W'(2048);
    localparam logic [QUAL_W-1:0] RST_QUALITY_THRESHOLD = QUAL_W'(0);
    localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE       = WIN_W'(4);

    // Trim outcome codes
    typedef enum logic [2:0] {
        OUT_KEPT         = 3'd0,
        OUT_UNSAMPLED    = 3'd1,
        OUT_LEFT_SHORT   = 3'd2,
        OUT_RIGHT_SHORT  = 3'd3,
        OUT_QUALITY_FAIL = 3'd4,
        OUT_UNDER_MIN    = 3'd5
    } outcome_t;

    // What a read leaves behind after its last base
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic             fail_seen;
        logic [POS_W-1:0] first_fail;
    } read_summary_t;

endpackage

`default_nettype wire

### rtl/core/rsqt_window.sv
// ----------------------------------------------------------------------------
// Sliding window quality tracker
// Counts bases of the current read, keeps the last window of Phred values
// after the left clip and records the first window whose sum falls short.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqt_window (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          base_en,
    input  wire logic [rsqt_pkg::QUAL_W-1:0]   quality_char,
    input  wire logic                          last_base,
    input  wire logic [rsqt_pkg::POS_W-1:0]    left_clip,
    input  wire logic [rsqt_pkg::QUAL_W-1:0]   quality_threshold,
    input  wire logic [rsqt_pkg::WIN_W-1:0]    win_k,
    output rsqt_pkg::read_summary_t            summary
);

    logic [rsqt_pkg::QUAL_W-1:0] line_reg [rsqt_pkg::MAX_WINDOW];
    logic [rsqt_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [rsqt_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [rsqt_pkg::POS_W-1:0]  ffs_reg, ffs_next;
    logic                        fail_reg, fail_next;

    logic [rsqt_pkg::QUAL_W-1:0]    phred;
    logic                           in_range;
    logic                           in_region;
    logic [rsqt_pkg::POS_W-1:0]     rel;
    logic [rsqt_pkg::POS_W:0]       rel_plus;
    logic [rsqt_pkg::POS_W-1:0]     old_pos;
    logic [rsqt_pkg::WIN_IDX_W-1:0] old_idx;
    logic [rsqt_pkg::WIN_IDX_W-1:0] wr_idx;
    logic [rsqt_pkg::QUAL_W-1:0]    old_q;
    logic [rsqt_pkg::SUM_W-1:0]     sum_trim;
    logic [rsqt_pkg::SUM_W-1:0]     sum_new;
    logic [rsqt_pkg::THR_W-1:0]     thr_total;
    logic                           fail_hit;

    // Phred value, characters below the offset count as zero
    assign phred = (quality_char >= rsqt_pkg::PHRED_OFFSET) ?
                   (quality_char - rsqt_pkg::PHRED_OFFSET) : '0;

    // Position within the clipped region
    assign in_range  = (pos_reg < rsqt_pkg::POS_W'(rsqt_pkg::MAX_READ_LEN));
    assign in_region = in_range && (pos_reg >= left_clip);
    assign rel       = pos_reg - left_clip;
    assign rel_plus  = {1'b0, rel} + (rsqt_pkg::POS_W+1)'(1);
    assign old_pos   = rel - rsqt_pkg::POS_W'(win_k);
    assign old_idx   = old_pos[rsqt_pkg::WIN_IDX_W-1:0];
    assign wr_idx    = rel[rsqt_pkg::WIN_IDX_W-1:0];
    assign old_q     = line_reg[old_idx];

    // Window sum: drop the value leaving the window, add the new one
    always_comb
    begin
        if (rel >= rsqt_pkg::POS_W'(win_k))
        begin
            if (sum_reg >= rsqt_pkg::SUM_W'(old_q))
                sum_trim = sum_reg - rsqt_pkg::SUM_W'(old_q);
            else
                sum_trim = '0;
        end
        else
        begin
            sum_trim = sum_reg;
        end
    end

    assign sum_new   = sum_trim + rsqt_pkg::SUM_W'(phred);
    assign thr_total = rsqt_pkg::THR_W'(quality_threshold) * rsqt_pkg::THR_W'(win_k);
    assign fail_hit  = (rel_plus >= (rsqt_pkg::POS_W+1)'(win_k)) && !fail_reg &&
                       (sum_new < rsqt_pkg::SUM_W'(thr_total));

    // Next state of the read tracker
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        fail_next = fail_reg;
        ffs_next  = ffs_reg;
        if (in_range)
            pos_next = pos_reg + rsqt_pkg::POS_W'(1);
        if (in_region)
        begin
            sum_next = sum_new;
            if (fail_hit)
            begin
                fail_next = 1'b1;
                ffs_next  = rsqt_pkg::POS_W'(rel_plus - (rsqt_pkg::POS_W+1)'(win_k));
            end
        end
    end

    assign summary.len        = pos_next;
    assign summary.fail_seen  = fail_next;
    assign summary.first_fail = ffs_next;

    // State update; the last base of a read clears everything for the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            fail_reg <= 1'b0;
            ffs_reg  <= '0;
            for (int i = 0; i < rsqt_pkg::MAX_WINDOW; i++)
                line_reg[i] <= '0;
        end
        else if (base_en)
        begin
            if (last_base)
            begin
                pos_reg  <= '0;
                sum_reg  <= '0;
                fail_reg <= 1'b0;
                ffs_reg  <= '0;
                for (int i = 0; i < rsqt_pkg::MAX_WINDOW; i++)
                    line_reg[i] <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                sum_reg  <= sum_next;
                fail_reg <= fail_next;
                ffs_reg  <= ffs_next;
                if (in_region)
                    line_reg[wr_idx] <= phred;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/read_sample_clip_quality_trim_unit.sv
// Each result passes the input, decision and output registers after a read's last base.
// Throughput: one base per cycle; only a last base can stall, and only while the
// decision and output registers both hold results that downstream has not taken.
// A read of N bases yields one result.
// Reset (rst_n low, asynchronous): registers return to their defaults, the
// window tracker and all totals clear; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
// Read sample, clip and quality trim unit
// Streams quality characters of one read at a time and gives one keep/trim
// decision per read, with running totals of reads and bases.
// ----------------------------------------------------------------------------
`default_nettype none

module read_sample_clip_quality_trim_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rsqt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rsqt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Base input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [6:0] quality_char, [20:7] sample_draw, [23:21] zero
    input  wire logic [rsqt_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,     // last_base
    // Decision output stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] keep, [3:1] outcome, [15:4] trim_start, [27:16] trim_length,
    // [59:28] reads_in_total, [91:60] reads_out_total,
    // [131:92] bases_out_total, [135:132] zero
    output logic [rsqt_pkg::OUT_DATA_W-1:0]        m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rsqt_pkg::DRAW_W-1:0] sample_thr_reg;
    logic [rsqt_pkg::POS_W-1:0]  left_clip_reg;
    logic [rsqt_pkg::POS_W-1:0]  right_clip_reg;
    logic [rsqt_pkg::POS_W-1:0]  min_len_reg;
    logic [rsqt_pkg::POS_W-1:0]  max_len_reg;
    logic [rsqt_pkg::QUAL_W-1:0] qual_thr_reg;
    logic [rsqt_pkg::WIN_W-1:0]  win_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_thr_reg <= rsqt_pkg::RST_SAMPLE_THRESHOLD;
            left_clip_reg  <= rsqt_pkg::RST_LEFT_CLIP;
            right_clip_reg <= rsqt_pkg::RST_RIGHT_CLIP;
            min_len_reg    <= rsqt_pkg::RST_MIN_LENGTH;
            max_len_reg    <= rsqt_pkg::RST_MAX_LENGTH;
            qual_thr_reg   <= rsqt_pkg::RST_QUALITY_THRESHOLD;
            win_size_reg   <= rsqt_pkg::RST_WINDOW_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rsqt_pkg::cfg_reg_t'(cfg_index))
                rsqt_pkg::REG_SAMPLE_THRESHOLD:
                    sample_thr_reg <= cfg_data[rsqt_pkg::DRAW_W-1:0];
                rsqt_pkg::REG_LEFT_CLIP:
                    left_clip_reg  <= cfg_data[rsqt_pkg::POS_W-1:0];
                rsqt_pkg::REG_RIGHT_CLIP:
                    right_clip_reg <= cfg_data[rsqt_pkg::POS_W-1:0];
                rsqt_pkg::REG_MIN_LENGTH:
                    min_len_reg    <= cfg_data[rsqt_pkg::POS_W-1:0];
                rsqt_pkg::REG_MAX_LENGTH:
                    max_len_reg    <= cfg_data[rsqt_pkg::POS_W-1:0];
                rsqt_pkg::REG_QUALITY_THRESHOLD:
                    qual_thr_reg   <= cfg_data[rsqt_pkg::QUAL_W-1:0];
                rsqt_pkg::REG_WINDOW_SIZE:
                    win_size_reg   <= cfg_data[rsqt_pkg::WIN_W-1:0];
                default:
                    ; // unused index, write dropped
            endcase
        end
    end

    // Effective window size, clamped to 1..MAX_WINDOW
    logic [rsqt_pkg::WIN_W-1:0] win_k;

    always_comb
    begin
        if (win_size_reg == '0)
            win_k = rsqt_pkg::WIN_W'(1);
        else if (win_size_reg > rsqt_pkg::WIN_W'(rsqt_pkg::MAX_WINDOW))
            win_k = rsqt_pkg::WIN_W'(rsqt_pkg::MAX_WINDOW);
        else
            win_k = win_size_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline handshakes: input register, decision register, output register
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [rsqt_pkg::QUAL_W-1:0]   in_qual_reg;
    logic                          in_last_reg;
    logic [rsqt_pkg::DRAW_W-1:0]   in_draw_reg;

    logic                          dec_valid_reg;
    rsqt_pkg::read_summary_t       dec_sum_reg;
    logic [rsqt_pkg::DRAW_W-1:0]   dec_draw_reg;

    logic                          out_valid_reg;
    logic [rsqt_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic out_ready;
    logic dec_ready;
    logic base_fire;
    logic dec_fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign dec_ready = !dec_valid_reg || out_ready;
    assign dec_fire  = dec_valid_reg && out_ready;
    // A base without a decision never waits for downstream room
    assign base_fire = in_valid_reg && (!in_last_reg || dec_ready);
    assign s_tready  = !in_valid_reg || base_fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_qual_reg <= s_tdata[rsqt_pkg::QUAL_W-1:0];
            in_last_reg <= s_tlast;
            in_draw_reg <= s_tdata[rsqt_pkg::QUAL_W +: rsqt_pkg::DRAW_W];
        end
    end

    // ------------------------------------------------------------------
    // Window tracker
    // ------------------------------------------------------------------
    rsqt_pkg::read_summary_t read_summary;

    rsqt_window u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .base_en           (base_fire),
        .quality_char      (in_qual_reg),
        .last_base         (in_last_reg),
        .left_clip         (left_clip_reg),
        .quality_threshold (qual_thr_reg),
        .win_k             (win_k),
        .summary           (read_summary)
    );

    // Decision register: loaded by the last base of each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_valid_reg <= 1'b0;
        else if (dec_ready)
            dec_valid_reg <= base_fire && in_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (base_fire && in_last_reg)
        begin
            dec_sum_reg  <= read_summary;
            dec_draw_reg <= in_draw_reg;
        end
    end

    // ------------------------------------------------------------------
    // Trim decision
    // ------------------------------------------------------------------
    rsqt_pkg::outcome_t          outcome;
    logic [rsqt_pkg::POS_W-1:0]  clip_len;
    logic [rsqt_pkg::POS_W-1:0]  cap_len;
    logic [rsqt_pkg::POS_W-1:0]  region_len;
    logic [rsqt_pkg::POS_W-1:0]  kept_len;
    logic [rsqt_pkg::POS_W-1:0]  last_start;
    logic                        keep;

    assign clip_len = dec_sum_reg.len - left_clip_reg;
    assign cap_len  = (max_len_reg > rsqt_pkg::POS_W'(rsqt_pkg::MAX_READ_LEN)) ?
                      rsqt_pkg::POS_W'(rsqt_pkg::MAX_READ_LEN) : max_len_reg;

    always_comb
    begin
        outcome    = rsqt_pkg::OUT_KEPT;
        region_len = clip_len;
        if (right_clip_reg != '0)
            region_len = clip_len - right_clip_reg;
        if (region_len > cap_len)
            region_len = cap_len;
        last_start = region_len - rsqt_pkg::POS_W'(win_k);
        kept_len   = region_len;

        if (dec_draw_reg > sample_thr_reg)
            outcome = rsqt_pkg::OUT_UNSAMPLED;
        else if (dec_sum_reg.len <= left_clip_reg)
            outcome = rsqt_pkg::OUT_LEFT_SHORT;
        else if ((right_clip_reg != '0) && (clip_len <= right_clip_reg))
            outcome = rsqt_pkg::OUT_RIGHT_SHORT;
        else
        begin
            // First failing window inside the region cuts the read there
            if ((qual_thr_reg != '0) && (region_len >= rsqt_pkg::POS_W'(win_k)) &&
                dec_sum_reg.fail_seen && (dec_sum_reg.first_fail <= last_start))
            begin
                if (dec_sum_reg.first_fail == '0)
                    outcome = rsqt_pkg::OUT_QUALITY_FAIL;
                else
                    kept_len = dec_sum_reg.first_fail;
            end
            if ((outcome == rsqt_pkg::OUT_KEPT) && (kept_len < min_len_reg))
                outcome = rsqt_pkg::OUT_UNDER_MIN;
        end
    end

    assign keep = (outcome == rsqt_pkg::OUT_KEPT);

    // ------------------------------------------------------------------
    // Running totals
    // ------------------------------------------------------------------
    logic [rsqt_pkg::READS_W-1:0] reads_in_reg,  reads_in_next;
    logic [rsqt_pkg::READS_W-1:0] reads_out_reg, reads_out_next;
    logic [rsqt_pkg::BASES_W-1:0] bases_out_reg, bases_out_next;
    logic [rsqt_pkg::BASES_W:0]   bases_sum;

    assign bases_sum = {1'b0, bases_out_reg} + (rsqt_pkg::BASES_W+1)'(kept_len);

    always_comb
    begin
        reads_in_next  = reads_in_reg + rsqt_pkg::READS_W'(1);
        reads_out_next = reads_out_reg;
        bases_out_next = bases_out_reg;
        if (keep)
        begin
            reads_out_next = reads_out_reg + rsqt_pkg::READS_W'(1);
            bases_out_next = bases_sum[rsqt_pkg::BASES_W] ? rsqt_pkg::BASES_MAX :
                             bases_sum[rsqt_pkg::BASES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_in_reg  <= '0;
            reads_out_reg <= '0;
            bases_out_reg <= '0;
        end
        else if (dec_fire)
        begin
            reads_in_reg  <= reads_in_next;
            reads_out_reg <= reads_out_next;
            bases_out_reg <= bases_out_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= dec_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dec_fire)
        begin
            out_data_reg <= {
                4'b0000,
                bases_out_next,
                reads_out_next,
                reads_in_next,
                keep ? kept_len : rsqt_pkg::POS_W'(0),
                keep ? left_clip_reg : rsqt_pkg::POS_W'(0),
                outcome,
                keep
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### rtl/core/rsqt_checker.sv
// ----------------------------------------------------------------------------
// Read sample, clip and quality trim: port checker
// Watches the output stream of the top level and flags inconsistent decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqt_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [rsqt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // Keep flag agrees with the outcome code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == rsqt_pkg::OUT_KEPT)))
    else $error("keep flag disagrees with outcome");

    // Outcome code is one of the defined reasons
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= rsqt_pkg::OUT_UNDER_MIN))
    else $error("undefined outcome code");

    // A dropped read reports no trim region
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[27:4] == '0))
    else $error("dropped read carries a trim region");

endmodule

bind read_sample_clip_quality_trim_unit rsqt_checker u_rsqt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
